// ===== rtl/ial_pkg.sv =====
// Shared types, codes and control store for the indexed array list engine.
package ial_pkg;

	// Command codes
	localparam logic [2:0] CMD_APPEND    = 3'd0;
	localparam logic [2:0] CMD_INSERT    = 3'd1;
	localparam logic [2:0] CMD_REMOVE_AT = 3'd2;
	localparam logic [2:0] CMD_REMOVE_V  = 3'd3;
	localparam logic [2:0] CMD_READ      = 3'd4;
	localparam logic [2:0] CMD_FIND      = 3'd5;
	localparam logic [2:0] CMD_CLEAR     = 3'd6;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_POS   = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [6:0] NO_INDEX = 7'h7F;

	// Datapath actions, one per control word
	localparam logic [3:0] ACT_NOP    = 4'd0;
	localparam logic [3:0] ACT_CHECK  = 4'd1;
	localparam logic [3:0] ACT_APPEND = 4'd2;
	localparam logic [3:0] ACT_SHUP   = 4'd3;
	localparam logic [3:0] ACT_PUTV   = 4'd4;
	localparam logic [3:0] ACT_RDPOS  = 4'd5;
	localparam logic [3:0] ACT_TAKE   = 4'd6;
	localparam logic [3:0] ACT_SHDN   = 4'd7;
	localparam logic [3:0] ACT_DEC    = 4'd8;
	localparam logic [3:0] ACT_SRCH   = 4'd9;
	localparam logic [3:0] ACT_SETPOS = 4'd10;
	localparam logic [3:0] ACT_CLR    = 4'd11;
	localparam logic [3:0] ACT_DONE   = 4'd12;

	// Branch kinds
	localparam logic [2:0] BR_WAIT = 3'd0; // hold until a beat is taken
	localparam logic [2:0] BR_NEXT = 3'd1;
	localparam logic [2:0] BR_JUMP = 3'd2;
	localparam logic [2:0] BR_LOOP = 3'd3; // hold while cond, then target
	localparam logic [2:0] BR_DISP = 3'd4; // error to done, else command entry
	localparam logic [2:0] BR_ERR  = 3'd5; // error to done, else target

	localparam int UPC_W = 4;

	// Program addresses
	localparam logic [UPC_W-1:0] UA_WAIT     = 4'd0;
	localparam logic [UPC_W-1:0] UA_CHECK    = 4'd1;
	localparam logic [UPC_W-1:0] UA_APPEND   = 4'd2;
	localparam logic [UPC_W-1:0] UA_SHUP     = 4'd3;
	localparam logic [UPC_W-1:0] UA_PUTV     = 4'd4;
	localparam logic [UPC_W-1:0] UA_RM_RD    = 4'd5;
	localparam logic [UPC_W-1:0] UA_RM_TAKE  = 4'd6;
	localparam logic [UPC_W-1:0] UA_SHDN     = 4'd7;
	localparam logic [UPC_W-1:0] UA_DEC      = 4'd8;
	localparam logic [UPC_W-1:0] UA_RV_SRCH  = 4'd9;
	localparam logic [UPC_W-1:0] UA_SETPOS   = 4'd10;
	localparam logic [UPC_W-1:0] UA_RD_RD    = 4'd11;
	localparam logic [UPC_W-1:0] UA_RD_TAKE  = 4'd12;
	localparam logic [UPC_W-1:0] UA_FIND     = 4'd13;
	localparam logic [UPC_W-1:0] UA_CLR      = 4'd14;
	localparam logic [UPC_W-1:0] UA_DONE     = 4'd15;

	typedef struct packed {
		logic [3:0]       act;
		logic [2:0]       br;
		logic [UPC_W-1:0] tgt;
	} uword_t;

	// Sequencer to datapath
	typedef struct packed {
		logic [3:0] act;
		logic       idle;
	} ctl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic       cond;
		logic       err;
		logic [2:0] cmd;
	} flags_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [31:0]       item;
		logic signed [6:0] found_index;
		logic [6:0]        length;
		logic              is_empty;
	} result_t;

	// Control store
	function automatic uword_t ucode(input logic [UPC_W-1:0] a);
		uword_t w;
		case (a)
			UA_WAIT:    w = '{ACT_NOP,    BR_WAIT, UA_WAIT};
			UA_CHECK:   w = '{ACT_CHECK,  BR_DISP, UA_DONE};
			UA_APPEND:  w = '{ACT_APPEND, BR_JUMP, UA_DONE};
			UA_SHUP:    w = '{ACT_SHUP,   BR_LOOP, UA_PUTV};
			UA_PUTV:    w = '{ACT_PUTV,   BR_JUMP, UA_DONE};
			UA_RM_RD:   w = '{ACT_RDPOS,  BR_NEXT, UA_WAIT};
			UA_RM_TAKE: w = '{ACT_TAKE,   BR_NEXT, UA_WAIT};
			UA_SHDN:    w = '{ACT_SHDN,   BR_LOOP, UA_DEC};
			UA_DEC:     w = '{ACT_DEC,    BR_JUMP, UA_DONE};
			UA_RV_SRCH: w = '{ACT_SRCH,   BR_LOOP, UA_SETPOS};
			UA_SETPOS:  w = '{ACT_SETPOS, BR_ERR,  UA_SHDN};
			UA_RD_RD:   w = '{ACT_RDPOS,  BR_NEXT, UA_WAIT};
			UA_RD_TAKE: w = '{ACT_TAKE,   BR_JUMP, UA_DONE};
			UA_FIND:    w = '{ACT_SRCH,   BR_LOOP, UA_DONE};
			UA_CLR:     w = '{ACT_CLR,    BR_JUMP, UA_DONE};
			UA_DONE:    w = '{ACT_DONE,   BR_LOOP, UA_WAIT};
			default:    w = '{ACT_NOP,    BR_JUMP, UA_WAIT};
		endcase
		return w;
	endfunction

	// Entry point of each command
	function automatic logic [UPC_W-1:0] entry(input logic [2:0] cmd);
		logic [UPC_W-1:0] e;
		case (cmd)
			CMD_APPEND:    e = UA_APPEND;
			CMD_INSERT:    e = UA_SHUP;
			CMD_REMOVE_AT: e = UA_RM_RD;
			CMD_REMOVE_V:  e = UA_RV_SRCH;
			CMD_READ:      e = UA_RD_RD;
			CMD_FIND:      e = UA_FIND;
			CMD_CLEAR:     e = UA_CLR;
			default:       e = UA_DONE;
		endcase
		return e;
	endfunction

endpackage

// ===== rtl/ial_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ial_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/ial_seq.sv =====
// Microcode sequencer: step counter, control store fetch and branching.
module ial_seq import ial_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  logic   busy,
	input  flags_t flags,
	output ctl_t   ctl
);

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_d;
	uword_t           uw;
	logic             cond;

	assign uw       = ucode(upc_q);
	assign ctl.act  = uw.act;
	assign ctl.idle = (upc_q == UA_WAIT);

	// The done step waits on the output register, other loops on the datapath
	assign cond = (uw.act == ACT_DONE) ? busy : flags.cond;

	// Select next step
	always_comb begin
		case (uw.br)
			BR_WAIT: upc_d = accept ? upc_q + 1'b1 : upc_q;
			BR_NEXT: upc_d = upc_q + 1'b1;
			BR_JUMP: upc_d = uw.tgt;
			BR_LOOP: upc_d = cond ? upc_q : uw.tgt;
			BR_DISP: upc_d = flags.err ? UA_DONE : entry(flags.cmd);
			BR_ERR:  upc_d = flags.err ? UA_DONE : uw.tgt;
			default: upc_d = UA_WAIT;
		endcase
	end

	// Advance step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_WAIT;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

// ===== rtl/ial_dp.sv =====
// Datapath: command registers, entry count, walk pointer, compare and list store.
module ial_dp import ial_pkg::*; #(
	parameter int CAPACITY  = 64,
	parameter int ITEM_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [2:0]  cmd,
	input  logic [5:0]  position,
	input  logic [31:0] value,
	input  ctl_t        ctl,
	output flags_t      flags,
	output result_t     res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 6) ? CW : 6;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [2:0]           cmd_q;
	logic [5:0]           pos_q;
	logic [ITEM_BITS-1:0] val_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        ptr_q;
	logic [1:0]           status_q;
	logic [ITEM_BITS-1:0] item_q;
	logic [AW-1:0]        fidx_q;
	logic                 hit_q;
	logic                 pend_q;
	logic [AW-1:0]        wa_q;
	logic                 cmp_v_q;
	logic [AW-1:0]        cidx_q;

	logic [1:0]           chk_status;
	logic                 full;
	logic [XW-1:0]        pos_x;
	logic [XW-1:0]        cnt_x;
	logic [CW-1:0]        pos_c;
	logic [CW:0]          ptr_p1;
	logic                 up_more;
	logic                 dn_more;
	logic                 srch_more;
	logic                 hit_now;
	logic                 loop_cond;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ITEM_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [ITEM_BITS-1:0] ram_rdata;

	ial_ram #(
		.WIDTH (ITEM_BITS),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Bounds and capacity check on the held command
	assign full  = (count_q == CAP_C);
	assign pos_x = XW'(pos_q);
	assign cnt_x = XW'(count_q);
	assign pos_c = CW'(pos_q);

	always_comb begin
		case (cmd_q)
			CMD_APPEND:    chk_status = full ? ST_FULL : ST_OK;
			CMD_INSERT:    chk_status = full ? ST_FULL :
			                            (pos_x > cnt_x) ? ST_BAD_POS : ST_OK;
			CMD_REMOVE_AT,
			CMD_READ:      chk_status = (pos_x >= cnt_x) ? ST_BAD_POS : ST_OK;
			default:       chk_status = ST_OK;
		endcase
	end

	// Loop conditions
	assign ptr_p1    = {1'b0, ptr_q} + 1'b1;
	assign up_more   = (ptr_q > pos_c);
	assign dn_more   = (ptr_p1 < {1'b0, count_q});
	assign hit_now   = cmp_v_q && (ram_rdata == val_q);
	assign srch_more = !hit_now && ((ptr_q < count_q) || cmp_v_q);

	always_comb begin
		case (ctl.act)
			ACT_SHUP: loop_cond = up_more;
			ACT_SHDN: loop_cond = dn_more;
			ACT_SRCH: loop_cond = srch_more;
			default:  loop_cond = 1'b0;
		endcase
	end
	assign flags.cond = loop_cond;
	assign flags.err = (ctl.act == ACT_CHECK) ? (chk_status != ST_OK) : (status_q != ST_OK);
	assign flags.cmd = cmd_q;

	// Store read address
	always_comb begin
		case (ctl.act)
			ACT_RDPOS: ram_raddr = AW'(pos_q);
			ACT_SHUP:  ram_raddr = AW'(ptr_q - 1'b1);
			ACT_SHDN:  ram_raddr = AW'(ptr_p1);
			default:   ram_raddr = AW'(ptr_q);
		endcase
	end

	// Store write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_q;
		ram_wdata = ram_rdata;
		case (ctl.act)
			ACT_APPEND: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(count_q);
				ram_wdata = val_q;
			end
			ACT_PUTV: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(pos_q);
				ram_wdata = val_q;
			end
			ACT_SHUP, ACT_SHDN: begin
				ram_we = pend_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Capture the command beat
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			pos_q <= position;
			val_q <= ITEM_BITS'(value);
		end
	end

	// Per-command working registers
	always_ff @(posedge clk) begin
		case (ctl.act)
			ACT_CHECK: begin
				status_q <= chk_status;
				item_q   <= '0;
				if (cmd_q == CMD_INSERT) begin
					ptr_q <= count_q;
				end else if (cmd_q == CMD_REMOVE_V || cmd_q == CMD_FIND) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= pos_c;
				end
			end
			ACT_SHUP: begin
				if (up_more) begin
					wa_q  <= AW'(ptr_q);
					ptr_q <= ptr_q - 1'b1;
				end
			end
			ACT_SHDN: begin
				if (dn_more) begin
					wa_q  <= AW'(ptr_q);
					ptr_q <= CW'(ptr_p1);
				end
			end
			ACT_TAKE: begin
				item_q <= ram_rdata;
			end
			ACT_SRCH: begin
				if (hit_now) begin
					fidx_q <= cidx_q;
				end else if (ptr_q < count_q) begin
					cidx_q <= AW'(ptr_q);
					ptr_q  <= CW'(ptr_p1);
				end else if (!cmp_v_q) begin
					status_q <= ST_NOT_FOUND;
				end
			end
			ACT_SETPOS: begin
				if (hit_q) begin
					ptr_q  <= CW'(fidx_q);
					item_q <= val_q;
				end
			end
			default: begin
				ptr_q <= ptr_q;
			end
		endcase
	end

	// Control state: count, pending move, pending compare and match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
			cmp_v_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			case (ctl.act)
				ACT_CHECK: begin
					pend_q  <= 1'b0;
					cmp_v_q <= 1'b0;
					hit_q   <= 1'b0;
				end
				ACT_APPEND, ACT_PUTV: begin
					count_q <= count_q + 1'b1;
				end
				ACT_SHUP: begin
					pend_q <= up_more;
				end
				ACT_SHDN: begin
					pend_q <= dn_more;
				end
				ACT_DEC: begin
					count_q <= count_q - 1'b1;
				end
				ACT_SRCH: begin
					if (hit_now) begin
						hit_q   <= 1'b1;
						cmp_v_q <= 1'b0;
					end else begin
						cmp_v_q <= (ptr_q < count_q);
					end
				end
				ACT_CLR: begin
					count_q <= '0;
				end
				default: begin
					pend_q <= pend_q;
				end
			endcase
		end
	end

	// Result fields
	assign res.status      = status_q;
	assign res.item        = 32'(item_q);
	assign res.found_index = hit_q ? 7'(fidx_q) : NO_INDEX;
	assign res.length      = 7'(count_q);
	assign res.is_empty    = (count_q == '0);

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CAP_C)
		else $error("entry count beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (ctl.act == ACT_SHUP || ctl.act == ACT_SHDN))
		else $error("pending move outside a shift loop");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmp_v_q |-> (ctl.act == ACT_SRCH))
		else $error("pending compare outside a search");

	assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> (status_q == ST_OK))
		else $error("match recorded with an error status");
`endif

endmodule

// ===== rtl/indexed_array_list_engine.sv =====
// Top level of the indexed array list engine: stream ports and result register.
//
// One command beat in, one result beat out. A command walks the entries that it
// shifts or searches: insert from the end down to the position, remove at from
// the position to the end, find from the head to the match or the end, and
// remove value searches likewise and on a hit shifts down from the match. Append,
// clear, read and the bounds or full errors walk no entries. The next beat is
// taken only after the result step, and the result step holds while the output
// register is still occupied.
// The walk is set by the single read and single write port of the entry store,
// which moves one entry per cycle. The next command is taken once the current
// one has reached its result, while that result may still wait in the output
// register. Unused command code 7 gives status ok and changes nothing.
module indexed_array_list_engine import ial_pkg::*; #(
	parameter int CAPACITY  = 64,
	parameter int ITEM_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // position[5:0], value[37:6], zero pad
	input  logic [2:0]  s_tuser,  // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // item[31:0], found_index[38:32], length[45:39],
	                              // is_empty[46], zero pad
	output logic [1:0]  m_tuser   // status[1:0]
);

	ctl_t    ctl;
	flags_t  flags;
	result_t res;
	result_t res_q;
	logic    m_tvalid_q;
	logic    accept;
	logic    busy;
	logic    load;

	assign s_tready = ctl.idle;
	assign accept   = s_tvalid && s_tready;
	assign busy     = m_tvalid_q && !m_tready;
	assign load     = (ctl.act == ACT_DONE) && !busy;

	ial_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.busy   (busy),
		.flags  (flags),
		.ctl    (ctl)
	);

	ial_dp #(
		.CAPACITY  (CAPACITY),
		.ITEM_BITS (ITEM_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (s_tuser),
		.position (s_tdata[5:0]),
		.value    (s_tdata[37:6]),
		.ctl      (ctl),
		.flags    (flags),
		.res      (res)
	);

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {1'b0, res_q.is_empty, res_q.length, res_q.found_index, res_q.item};

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy)
		else $error("result register overwritten before taken");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second command taken without a result step");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the indexed array list engine stream block.
`timescale 1ns / 100ps

module testbench import ial_pkg::*;;

	localparam int         ENTRY_CAP   = 64;
	localparam int         CYCLE_LIMIT = 1_000_000;
	localparam int         DRAIN_WAIT  = 300;
	localparam logic [2:0] CMD_UNUSED  = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // position[5:0], value[37:6], zero pad
	logic [2:0]  s_tuser;   // cmd[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // item[31:0], found_index[38:32], length[45:39], is_empty[46], pad
	logic [1:0]  m_tuser;   // status[1:0]

	// Predicted list contents, kept in step with accepted command beats
	logic [31:0] list_mem [ENTRY_CAP];
	int          list_len;
	result_t     pending_results [$];

	int failures;
	int commands_sent;
	int results_checked;
	int peak_len;
	int status_seen [4];
	int cycle_count;

	// Idle controls shared by the test tasks, the command sender and the result side
	bit src_idle;
	bit sink_idle;
	int sink_hold;

	indexed_array_list_engine #(
		.CAPACITY (ENTRY_CAP),
		.ITEM_BITS(32)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("indexed_array_list_engine test failed");
			$finish;
		end
	end

	// First position holding a value, -1 when absent
	function automatic int locate(input logic [31:0] v);
		for (int i = 0; i < list_len; i++)
			if (list_mem[i] == v)
				return i;
		return -1;
	endfunction

	// Close the gap left by a removed entry
	function automatic void drop_entry(input int at);
		for (int i = at; i + 1 < list_len; i++)
			list_mem[i] = list_mem[i + 1];
		list_len--;
	endfunction

	// Apply one command to the predicted list and return the result it gives
	function automatic result_t apply_command(input logic [2:0] cmd, input logic [5:0] pos,
			input logic [31:0] val);
		result_t r;
		int      at;
		r.status      = ST_OK;
		r.item        = '0;
		r.found_index = NO_INDEX;
		case (cmd)
			CMD_APPEND: begin
				if (list_len >= ENTRY_CAP) begin
					r.status = ST_FULL;
				end else begin
					list_mem[list_len] = val;
					list_len++;
				end
			end
			CMD_INSERT: begin
				// fullness wins over a bad position
				if (list_len >= ENTRY_CAP) begin
					r.status = ST_FULL;
				end else if (int'(pos) > list_len) begin
					r.status = ST_BAD_POS;
				end else begin
					for (int i = list_len; i > int'(pos); i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[pos] = val;
					list_len++;
				end
			end
			CMD_REMOVE_AT: begin
				if (int'(pos) >= list_len) begin
					r.status = ST_BAD_POS;
				end else begin
					r.item = list_mem[pos];
					drop_entry(int'(pos));
				end
			end
			CMD_REMOVE_V: begin
				at = locate(val);
				if (at < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.item        = list_mem[at];
					r.found_index = at[6:0];
					drop_entry(at);
				end
			end
			CMD_READ: begin
				if (int'(pos) >= list_len)
					r.status = ST_BAD_POS;
				else
					r.item = list_mem[pos];
			end
			CMD_FIND: begin
				at = locate(val);
				if (at < 0)
					r.status = ST_NOT_FOUND;
				else
					r.found_index = at[6:0];
			end
			CMD_CLEAR: list_len = 0;
			default: ;
		endcase
		r.length   = list_len[6:0];
		r.is_empty = (list_len == 0);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			failures++;
		end
	endfunction

	// Score result beats against predictions, predict each command beat
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with no command outstanding, actual %0h/%0h",
						$time, m_tuser, m_tdata);
					failures++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 32'(want.status), 32'(m_tuser));
					check_field("item", want.item, m_tdata[31:0]);
					check_field("found_index", {25'd0, want.found_index},
						{25'd0, m_tdata[38:32]});
					check_field("length", 32'(want.length), 32'(m_tdata[45:39]));
					check_field("is_empty", 32'(want.is_empty), 32'(m_tdata[46]));
					check_field("pad", 32'd0, 32'(m_tdata[47]));
					status_seen[m_tuser]++;
					results_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				pending_results.push_back(apply_command(s_tuser, s_tdata[5:0], s_tdata[37:6]));
				commands_sent++;
				if (list_len > peak_len)
					peak_len = list_len;
			end
		end
	end

	// Result side: random stalls per beat, or one long hold-off when asked
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (sink_hold > 0) begin
				stall     = sink_hold;
				sink_hold = 0;
			end else begin
				stall = sink_idle ? $urandom_range(0, 5) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Offer one command beat and hold it until taken
	task automatic send_command(input logic [2:0] cmd, input logic [5:0] pos,
			input logic [31:0] val);
		int gap;
		gap = src_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {2'b00, val, pos};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Error paths on an empty list, then the corner cases on a short list
	task automatic test_directed();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		send_command(CMD_READ,      6'd0,  32'd0);
		send_command(CMD_REMOVE_AT, 6'd0,  32'd0);
		send_command(CMD_REMOVE_V,  6'd0,  32'd0);
		send_command(CMD_FIND,      6'd0,  32'hFFFF_FFFF);
		send_command(CMD_INSERT,    6'd1,  32'd5);
		send_command(CMD_INSERT,    6'd0,  32'hFFFF_FFFF);
		send_command(CMD_APPEND,    6'd63, 32'd0);
		send_command(CMD_APPEND,    6'd0,  32'hA5A5_5A5A);
		send_command(CMD_INSERT,    6'd3,  32'd0);
		send_command(CMD_INSERT,    6'd1,  32'h1234_5678);
		send_command(CMD_FIND,      6'd0,  32'd0);
		send_command(CMD_REMOVE_V,  6'd0,  32'd0);
		send_command(CMD_READ,      6'd3,  32'd0);
		send_command(CMD_READ,      6'd63, 32'd0);
		send_command(CMD_REMOVE_AT, 6'd63, 32'd0);
		send_command(CMD_REMOVE_AT, 6'd0,  32'd0);
		send_command(CMD_UNUSED,    6'd63, 32'hFFFF_FFFF);
		send_command(CMD_REMOVE_AT, 6'd2,  32'd0);
		send_command(CMD_CLEAR,     6'd0,  32'd0);
		send_command(CMD_READ,      6'd0,  32'd0);
		send_command(CMD_FIND,      6'd0,  32'h1234_5678);
		send_command(CMD_INSERT,    6'd0,  32'h8000_0001);
		send_command(CMD_REMOVE_V,  6'd0,  32'h8000_0001);
		send_command(CMD_CLEAR,     6'd0,  32'd0);
	endtask

	// Fill to capacity, hit the full errors and the longest walks
	task automatic test_full_list();
		logic [31:0] fill_vals [ENTRY_CAP];
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		send_command(CMD_CLEAR, 6'd0, 32'd0);
		for (int k = 0; k < ENTRY_CAP; k++) begin
			fill_vals[k] = {25'($urandom_range(0, 32'h01FF_FFFF)), k[6:0]};
			send_command(CMD_APPEND, 6'($urandom_range(0, 63)), fill_vals[k]);
		end
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		send_command(CMD_APPEND,    6'd0,  32'd1);
		send_command(CMD_INSERT,    6'd0,  32'd2);
		send_command(CMD_INSERT,    6'd63, 32'd3);
		send_command(CMD_READ,      6'd63, 32'd0);
		send_command(CMD_FIND,      6'd0,  fill_vals[ENTRY_CAP - 1]);
		send_command(CMD_REMOVE_V,  6'd0,  fill_vals[0]);
		send_command(CMD_INSERT,    6'd0,  fill_vals[0]);
		send_command(CMD_REMOVE_AT, 6'd63, 32'd0);
		send_command(CMD_INSERT,    6'd63, 32'hFFFF_FFFF);
		send_command(CMD_REMOVE_AT, 6'd0,  32'd0);
		send_command(CMD_REMOVE_V,  6'd0,  32'hFFFF_FFFF);
		send_command(CMD_CLEAR,     6'd0,  32'd0);
	endtask

	// Random commands, mostly well-formed, with the list length drifting to a goal
	task automatic test_random(input int n);
		logic [2:0]  cmd;
		logic [5:0]  pos;
		logic [31:0] val;
		int          goal;
		int          hi;
		goal = 8;
		for (int k = 0; k < n; k++) begin
			// change idling and target length every so often
			if (k % 150 == 0) begin
				src_idle  = ($urandom_range(0, 3) != 0);
				sink_idle = ($urandom_range(0, 3) != 0);
				goal      = ($urandom_range(0, 4) == 0) ? ENTRY_CAP : $urandom_range(0, 12);
			end
			case ($urandom_range(0, 19))
				0:           cmd = CMD_CLEAR;
				1:           cmd = CMD_UNUSED;
				2, 3, 4, 5, 6, 7, 8: begin
					if (list_len < goal)
						cmd = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT;
					else
						cmd = $urandom_range(0, 1) ? CMD_REMOVE_AT : CMD_REMOVE_V;
				end
				9, 10:       cmd = CMD_APPEND;
				11, 12:      cmd = CMD_INSERT;
				13, 14:      cmd = CMD_REMOVE_AT;
				15:          cmd = CMD_REMOVE_V;
				16, 17:      cmd = CMD_READ;
				default:     cmd = CMD_FIND;
			endcase
			// positions mostly in range, sometimes anywhere
			hi = (cmd == CMD_INSERT) ? list_len : list_len - 1;
			if (hi > 63)
				hi = 63;
			if (hi < 0 || $urandom_range(0, 7) == 0)
				hi = 63;
			pos = 6'($urandom_range(0, hi));
			// values from a small pool, a live entry, or fully random
			case ($urandom_range(0, 3))
				0:       val = $urandom;
				1:       val = (list_len > 0) ? list_mem[$urandom_range(0, list_len - 1)]
				                              : $urandom;
				2:       val = ~32'($urandom_range(0, 7));
				default: val = 32'($urandom_range(0, 7));
			endcase
			send_command(cmd, pos, val);
		end
	endtask

	// Hold the result side off while commands keep coming
	task automatic test_backpressure();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		sink_hold = 500;
		for (int k = 0; k < 30; k++)
			send_command(k % 3 == 0 ? CMD_FIND : CMD_APPEND, 6'd0,
				32'($urandom_range(0, 7)));
	endtask

	initial begin
		clk      = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_APPEND;
		list_len = 0;
		foreach (list_mem[i])
			list_mem[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_list();
		test_backpressure();
		test_random(1020);

		// drain, then give the block time to show any stray beat
		s_tvalid  <= 1'b0;
		sink_idle = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("ran %0d commands and checked %0d results, longest list %0d of %0d",
			commands_sent, results_checked, peak_len, ENTRY_CAP);
		$display("status counts: ok %0d, bad position %0d, full %0d, not found %0d",
			status_seen[ST_OK], status_seen[ST_BAD_POS], status_seen[ST_FULL],
			status_seen[ST_NOT_FOUND]);
		if (failures == 0)
			$display("indexed_array_list_engine test passed");
		else
			$display("indexed_array_list_engine test failed");
		$finish;
	end

endmodule
